@@ hw/rtl/vdf_pkg.sv @@
// Shared types, constants and helpers for the voxel distance fusion block.
package vdf_pkg;

  localparam int IDX_W          = 18;
  localparam int DIST_W         = 16;
  localparam int WT_W           = 16;
  localparam int NODE_COUNT_DEF = 262144;
  localparam int DIV_STAGES     = 16;
  // products, magnitude, one stage per quotient bit
  localparam int PIPE_STAGES    = DIV_STAGES + 2;

  typedef enum logic [1:0] {
    MODE_WAVG   = 2'd0,
    MODE_UNION  = 2'd1,
    MODE_CONVEX = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_INIT_DIST = 2'd1;
  localparam logic [1:0] CFG_INIT_WT   = 2'd2;

  localparam logic CMD_FUSE = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         node_index;
    logic signed [DIST_W-1:0] new_distance;
    logic [WT_W-1:0]          new_weight;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_node_index;
    logic signed [DIST_W-1:0] fused_distance;
    logic [WT_W-1:0]          fused_weight;
    logic                     zero_weight_flag;
  } out_item_t;

  // One item in flight through the update pipeline.
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         node;
    logic                     oob;
    logic                     div;
    logic                     flag;
    logic signed [DIST_W-1:0] d;
    logic [WT_W-1:0]          w;
    logic signed [DIST_W-1:0] dn;
    logic [WT_W-1:0]          wn;
    logic [WT_W:0]            s;
    logic                     neg;
    logic signed [32:0]       p0;
    logic signed [32:0]       p1;
    logic [WT_W:0]            rem;
    logic [DIST_W-1:0]        q;
  } pipe_t;

  function automatic logic [DIST_W:0] mag17(logic signed [DIST_W-1:0] v);
    logic signed [DIST_W:0] e;
    e = {v[DIST_W-1], v};
    return v[DIST_W-1] ? (DIST_W+1)'(0) - e : e;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic pipe_t div_step(pipe_t x);
    pipe_t         y;
    logic [WT_W+1:0] t;
    logic [WT_W+1:0] diff;
    y = x;
    t = {x.rem, x.q[DIST_W-1]};
    diff = t - {1'b0, x.s};
    if (t >= {1'b0, x.s}) begin
      y.rem = diff[WT_W:0];
      y.q   = {x.q[DIST_W-2:0], 1'b1};
    end else begin
      y.rem = t[WT_W:0];
      y.q   = {x.q[DIST_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

@@ hw/rtl/vdf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/vdf_fuse_pipe.sv @@
// Update pipeline: products, weighted-average divider, rounding, output register.
module vdf_fuse_pipe #(
  parameter int NODE_COUNT = vdf_pkg::NODE_COUNT_DEF,
  parameter int AW         = $clog2(NODE_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vdf_pkg::pipe_t             head,
  output logic                       head_free,
  input  logic [vdf_pkg::IDX_W-1:0]  query_node,
  output logic                       busy,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [vdf_pkg::DIST_W-1:0] wdist,
  output logic [vdf_pkg::WT_W-1:0]   wwt,
  output logic                       out_valid,
  input  logic                       out_stall,
  output vdf_pkg::out_item_t         out_data
);
  import vdf_pkg::*;

  localparam int NST = PIPE_STAGES;

  pipe_t st  [NST];
  pipe_t nxt [NST];
  logic  free [NST];
  logic  free_o;

  logic signed [33:0]     num;
  logic [33:0]            an;
  logic                   up;
  logic [DIST_W:0]        qq;
  logic [DIST_W:0]        dd;
  logic signed [DIST_W-1:0] fin_d;
  logic [WT_W-1:0]        fin_w;

  // stall ripples back from the output register
  always_comb begin
    free_o = !out_valid || !out_stall;
    free[NST-1] = !st[NST-1].valid || free_o;
    for (int k = NST-2; k >= 0; k--) begin
      free[k] = !st[k].valid || free[k+1];
    end
  end
  assign head_free = free[0];

  always_comb begin
    nxt[0] = head;
    nxt[0].p0 = head.d * $signed({1'b0, head.w});
    nxt[0].p1 = head.dn * $signed({1'b0, head.wn});

    num = st[0].p0 + st[0].p1;
    an  = num[33] ? 34'(0) - num : num;
    nxt[1] = st[0];
    nxt[1].neg = num[33];
    nxt[1].rem = an[32:16];
    nxt[1].q   = an[15:0];

    for (int k = 2; k < NST; k++) begin
      nxt[k] = div_step(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else if (free[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  // round to nearest, ties away from zero
  always_comb begin
    up = {st[NST-1].rem, 1'b0} >= {1'b0, st[NST-1].s};
    qq = {1'b0, st[NST-1].q} + (DIST_W+1)'(up);
    dd = st[NST-1].neg ? (DIST_W+1)'(0) - qq : qq;
    if (st[NST-1].div) begin
      fin_d = dd[DIST_W-1:0];
      fin_w = st[NST-1].s[WT_W:1];
    end else begin
      fin_d = st[NST-1].d;
      fin_w = st[NST-1].w;
    end
  end

  assign we    = st[NST-1].valid && free_o && !st[NST-1].oob;
  assign waddr = AW'(st[NST-1].node);
  assign wdist = fin_d;
  assign wwt   = fin_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free_o) begin
      out_valid <= st[NST-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free_o) begin
      out_data.out_node_index   <= st[NST-1].node;
      out_data.fused_distance   <= fin_d;
      out_data.fused_weight     <= fin_w;
      out_data.zero_weight_flag <= st[NST-1].flag;
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int k = 0; k < NST; k++) begin
      busy = busy || (st[k].valid && st[k].node == query_node);
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    st[NST-1].valid && st[NST-1].div |-> st[NST-1].s != '0)
    else $error("divider item with zero weight sum");

  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(out_data.out_node_index) >= 32'(NODE_COUNT))
      |-> out_data.fused_distance == '0 && out_data.fused_weight == '0)
    else $error("out-of-range node reported nonzero contents");

  a_oob_nowrite: assert property (@(posedge clk) disable iff (rst)
    we |-> 32'(st[NST-1].node) < 32'(NODE_COUNT))
    else $error("write to out-of-range node");

endmodule

@@ hw/rtl/voxel_distance_fusion_core.sv @@
// Voxel distance fusion top level: config, node memories, read stage, interlock.
// Throughput: one item per cycle while out_stall is low; an item whose node is still
// in flight stalls the input until that earlier item has written back.
// Reset clears pipeline valids and config (mode 0, distance 0, weight 256);
// node memory contents are undefined until an initialize item writes them.
module voxel_distance_fusion_core #(
  parameter int NODE_COUNT = vdf_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vdf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vdf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import vdf_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  mode_t                    fusion_mode;
  logic signed [DIST_W-1:0] initial_distance;
  logic [WT_W-1:0]          initial_weight;

  logic        accept;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        s1_free;
  logic        head_free;
  logic        busy;
  logic        hazard;
  pipe_t       head;

  logic [DIST_W-1:0] d_q;
  logic [WT_W-1:0]   w_q;
  logic signed [DIST_W-1:0] d_st;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DIST_W-1:0] wdist;
  logic [WT_W-1:0]   wwt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fusion_mode      <= MODE_WAVG;
      initial_distance <= '0;
      initial_weight   <= WT_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:      fusion_mode      <= mode_t'(cfg_data[1:0]);
        CFG_INIT_DIST: initial_distance <= cfg_data;
        CFG_INIT_WT:   initial_weight   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // interlock: no new beat on a node that has not yet written back
  assign hazard   = busy || (s1_valid && s1_item.node_index == in_data.node_index);
  assign s1_free  = !s1_valid || head_free;
  assign in_stall = !s1_free || hazard;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
  end

  vdf_ram #(.WIDTH(DIST_W), .DEPTH(NODE_COUNT)) u_dist_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdist),
    .re    (accept),
    .raddr (AW'(in_data.node_index)),
    .rdata (d_q)
  );

  vdf_ram #(.WIDTH(WT_W), .DEPTH(NODE_COUNT)) u_wt_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wwt),
    .re    (accept),
    .raddr (AW'(in_data.node_index)),
    .rdata (w_q)
  );

  assign d_st = d_q;

  always_comb begin
    head       = '0;
    head.valid = s1_valid;
    head.node  = s1_item.node_index;
    head.dn    = s1_item.new_distance;
    head.wn    = s1_item.new_weight;
    head.oob   = 32'(s1_item.node_index) >= 32'(NODE_COUNT);
    head.d     = d_st;
    head.w     = w_q;
    head.s     = {1'b0, w_q} + {1'b0, s1_item.new_weight};
    priority if (head.oob) begin
      head.d = '0;
      head.w = '0;
    end else if (s1_item.cmd == CMD_INIT) begin
      head.d = initial_distance;
      head.w = initial_weight;
    end else begin
      unique case (fusion_mode)
        MODE_WAVG: begin
          if (head.s == '0) begin
            head.flag = 1'b1;
            head.w    = '0;
          end else begin
            head.div = 1'b1;
          end
        end
        MODE_UNION: begin
          if (s1_item.new_distance != '0 && (d_st == '0 ||
              mag17(d_st) > mag17(s1_item.new_distance))) begin
            head.d = s1_item.new_distance;
          end
        end
        MODE_CONVEX: begin
          if (s1_item.new_distance > 0) begin
            if (d_st < 0 || d_st > s1_item.new_distance) begin
              head.d = s1_item.new_distance;
            end
          end else if (d_st < 0 && d_st < s1_item.new_distance) begin
            head.d = s1_item.new_distance;
          end
        end
        MODE_NONE: ;
        default: ;
      endcase
    end
  end

  vdf_fuse_pipe #(.NODE_COUNT(NODE_COUNT), .AW(AW)) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_free  (head_free),
    .query_node (in_data.node_index),
    .busy       (busy),
    .we         (we),
    .waddr      (waddr),
    .wdist      (wdist),
    .wwt        (wwt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_no_raw_overlap: assert property (@(posedge clk) disable iff (rst)
    we && s1_valid |-> waddr != AW'(s1_item.node_index))
    else $error("write-back to a node held in the read stage");

  a_flag_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_weight_flag |-> fusion_mode == MODE_WAVG)
    else $error("zero weight flag outside weighted mode");

  a_flag_weight: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_weight_flag |-> out_data.fused_weight == '0)
    else $error("zero weight flag with nonzero weight");

endmodule
